// ===== hdl/bmg_pkg.sv =====
// bmg_pkg: shared widths, types and divider constants of the box mean gray filter
// no dependencies
`default_nettype none

package bmg_pkg;

  localparam int COLOR_BITS   = 8;
  localparam int WINDOW_SIZE  = 5;
  localparam int WINDOW_COUNT = 25;
  localparam int PIXEL_BITS   = 3 * COLOR_BITS;

  // one column of WINDOW_SIZE pixels, one window of WINDOW_COUNT pixels
  localparam int COL_W = $clog2(WINDOW_SIZE * ((1 << COLOR_BITS) - 1) + 1);
  localparam int SUM_W = $clog2(WINDOW_COUNT * ((1 << COLOR_BITS) - 1) + 1);

  // floor(s / WINDOW_COUNT) as (s * DIV_K) >> DIV_SH, exact for s < 2**SUM_W
  localparam int DIV_SH = SUM_W + 5;
  localparam int DIV_K  = (1 << DIV_SH) / WINDOW_COUNT + 1;
  localparam int DIV_KW = $clog2(DIV_K + 1);

  // floor(x / 3) as (x * DIV3_K) >> DIV3_SH, exact for x < 3 * 2**COLOR_BITS
  localparam int MSUM_W  = COLOR_BITS + 2;
  localparam int DIV3_SH = MSUM_W + 2;
  localparam int DIV3_K  = (1 << DIV3_SH) / 3 + 1;
  localparam int DIV3_KW = $clog2(DIV3_K + 1);

  typedef struct packed {
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
  } col_sums_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } win_sums_t;

endpackage

`default_nettype wire

// ===== hdl/box_mean_grayscale_filter.sv =====
// box_mean_grayscale_filter: 5x5 box mean over RGB888 columns, then grayscale
// top level; depends on bmg_pkg, bmg_cell and bmg_gray
//
// usage:
//   input channel in_valid / in_stall carries one column of five stacked RGB888
//   pixels (in_row0_pixel is the current line, in_row4_pixel four lines above).
//   result channel out_valid / out_stall carries the filtered intensity as
//   out_gray_level and replicated into all three bytes of out_gray_pixel.
//   an item is taken on a rising edge with valid high and stall low.
// throughput: one column per cycle while no result waits under out_stall; the
//   three pipeline stages advance together, the column cells on each accept.
// a column is added to the window as it is accepted; four cells hold the
//   channel sums of the four previous columns and pass them along on accept.
// reset: synchronous, active low; in_stall is high while reset is held, the
//   column cells clear to zero so the first four results average in black
//   columns; the pipeline empties.
// stall: while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised.
// line and frame edges are not treated specially.
`default_nettype none

module box_mean_grayscale_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] in_row0_pixel,
  input  wire logic [23:0] in_row1_pixel,
  input  wire logic [23:0] in_row2_pixel,
  input  wire logic [23:0] in_row3_pixel,
  input  wire logic [23:0] in_row4_pixel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_gray_pixel,
  output logic [7:0]       out_gray_level
);

  localparam int CB    = bmg_pkg::COLOR_BITS;
  localparam int NCELL = bmg_pkg::WINDOW_SIZE - 1;

  logic [23:0] rows [bmg_pkg::WINDOW_SIZE];
  bmg_pkg::col_sums_t col_new;
  bmg_pkg::col_sums_t cell_q [NCELL];
  bmg_pkg::col_sums_t cell_d [NCELL];
  bmg_pkg::win_sums_t sums_r, sums_nxt;
  logic v1_r, v2_r, out_valid_r;
  logic adv, accept;
  logic [CB-1:0] inten;

  assign rows[0] = in_row0_pixel;
  assign rows[1] = in_row1_pixel;
  assign rows[2] = in_row2_pixel;
  assign rows[3] = in_row3_pixel;
  assign rows[4] = in_row4_pixel;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || !rst_n;
  assign accept   = in_valid && !in_stall;

  // channel sums of the new column
  always_comb begin
    col_new = '0;
    for (int k = 0; k < bmg_pkg::WINDOW_SIZE; k++) begin
      col_new.r = col_new.r + bmg_pkg::COL_W'(rows[k][3*CB-1:2*CB]);
      col_new.g = col_new.g + bmg_pkg::COL_W'(rows[k][2*CB-1:CB]);
      col_new.b = col_new.b + bmg_pkg::COL_W'(rows[k][CB-1:0]);
    end
  end

  // cell 0 holds the newest earlier column, the last cell the oldest
  for (genvar c = 0; c < NCELL; c++) begin : g_cells
    if (c == 0) begin : g_head
      assign cell_d[c] = col_new;
    end else begin : g_link
      assign cell_d[c] = cell_q[c-1];
    end
    bmg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .col_in   (cell_d[c]),
      .col_out  (cell_q[c])
    );
  end

  always_comb begin
    sums_nxt.r = bmg_pkg::SUM_W'(col_new.r);
    sums_nxt.g = bmg_pkg::SUM_W'(col_new.g);
    sums_nxt.b = bmg_pkg::SUM_W'(col_new.b);
    for (int c = 0; c < NCELL; c++) begin
      sums_nxt.r = sums_nxt.r + bmg_pkg::SUM_W'(cell_q[c].r);
      sums_nxt.g = sums_nxt.g + bmg_pkg::SUM_W'(cell_q[c].g);
      sums_nxt.b = sums_nxt.b + bmg_pkg::SUM_W'(cell_q[c].b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sums_r <= sums_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  bmg_gray u_gray (
    .clk   (clk),
    .adv   (adv),
    .sums  (sums_r),
    .inten (inten)
  );

  assign out_valid      = out_valid_r;
  assign out_gray_level = 8'(inten);
  assign out_gray_pixel = {out_gray_level, out_gray_level, out_gray_level};

  // an accepted column is in the first stage on the next edge
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted column did not enter the pipeline");

  // items move from the middle stage to the output when the pipe advances
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv) |=> out_valid_r)
    else $error("item lost between stages");

  // a waiting result keeps its stage contents frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(v1_r) && $stable(v2_r) && out_valid_r))
    else $error("pipeline moved under a stalled result");

  // no column is taken while the output is blocked
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !accept)
    else $error("column accepted while result stalled");

endmodule

`default_nettype wire

// ===== hdl/bmg_cell.sv =====
// bmg_cell: one window column cell, holds the channel sums of one earlier column
// depends on bmg_pkg
`default_nettype none

module bmg_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift_en,
  input  wire bmg_pkg::col_sums_t col_in,
  output bmg_pkg::col_sums_t      col_out
);

  bmg_pkg::col_sums_t col_r;

  // cleared at reset so the first windows average in black columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

// ===== hdl/bmg_gray.sv =====
// bmg_gray: two pipeline stages from window sums to channel means to intensity
// depends on bmg_pkg
`default_nettype none

module bmg_gray (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire bmg_pkg::win_sums_t sums,
  output logic [bmg_pkg::COLOR_BITS-1:0] inten
);

  localparam int PW  = bmg_pkg::SUM_W + bmg_pkg::DIV_KW;
  localparam int P3W = bmg_pkg::MSUM_W + bmg_pkg::DIV3_KW;

  localparam logic [bmg_pkg::DIV_KW-1:0]  KDIV  = bmg_pkg::DIV_KW'(bmg_pkg::DIV_K);
  localparam logic [bmg_pkg::DIV3_KW-1:0] KDIV3 = bmg_pkg::DIV3_KW'(bmg_pkg::DIV3_K);

  logic [PW-1:0] prod_r, prod_g, prod_b;
  logic [bmg_pkg::COLOR_BITS-1:0] mean_r_r, mean_g_r, mean_b_r;
  logic [bmg_pkg::COLOR_BITS-1:0] mean_r_nxt, mean_g_nxt, mean_b_nxt;
  logic [bmg_pkg::MSUM_W-1:0] msum;
  logic [P3W-1:0] prod3;
  logic [bmg_pkg::COLOR_BITS-1:0] inten_r, inten_nxt;

  // divide by the window count through a reciprocal
  always_comb begin
    prod_r = PW'(sums.r) * PW'(KDIV);
    prod_g = PW'(sums.g) * PW'(KDIV);
    prod_b = PW'(sums.b) * PW'(KDIV);
    mean_r_nxt = bmg_pkg::COLOR_BITS'(prod_r >> bmg_pkg::DIV_SH);
    mean_g_nxt = bmg_pkg::COLOR_BITS'(prod_g >> bmg_pkg::DIV_SH);
    mean_b_nxt = bmg_pkg::COLOR_BITS'(prod_b >> bmg_pkg::DIV_SH);
  end

  // mean of the three channel means
  always_comb begin
    msum = bmg_pkg::MSUM_W'(mean_r_r) + bmg_pkg::MSUM_W'(mean_g_r)
         + bmg_pkg::MSUM_W'(mean_b_r);
    prod3 = P3W'(msum) * P3W'(KDIV3);
    inten_nxt = bmg_pkg::COLOR_BITS'(prod3 >> bmg_pkg::DIV3_SH);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_r_r <= mean_r_nxt;
      mean_g_r <= mean_g_nxt;
      mean_b_r <= mean_b_nxt;
      inten_r  <= inten_nxt;
    end
  end

  assign inten = inten_r;

endmodule

`default_nettype wire
